[rtl/euler_rotation_matrix_q12_defines.svh]
// assertion macros shared by the rotation matrix rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef EULER_ROTATION_MATRIX_Q12_DEFINES_SVH
`define EULER_ROTATION_MATRIX_Q12_DEFINES_SVH

// same-cycle implication
`define ERM_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/erm_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and sine table builder for the rotation matrix block
// no dependencies
package erm_pkg;

  localparam int SINE_ROM_ENTRIES = 2048;
  localparam int ROM_AW           = $clog2(SINE_ROM_ENTRIES);
  localparam int ANGLE_W          = ROM_AW + 1;
  localparam int QUARTER_TURN     = SINE_ROM_ENTRIES / 2;
  localparam int EIGHTH_TURN      = QUARTER_TURN / 2;
  localparam int FRAC_BITS        = 12;
  localparam int Q12_ONE          = 4096;
  localparam int MAG_W            = FRAC_BITS + 1;
  localparam int TRIG_W           = MAG_W + 1;
  localparam int ENTRY_W          = 16;
  localparam int PROD_W           = TRIG_W + ENTRY_W;
  localparam int SUM_W            = PROD_W + 1;

  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // rotation order codes
  localparam logic ORDER_ZYX = 1'b0;
  localparam logic ORDER_ZXY = 1'b1;

  // rows touched by a plane rotation: the second row is always row 2
  localparam logic [1:0] ROW_Y_P = 2'd0;
  localparam logic [1:0] ROW_X_P = 2'd1;
  localparam logic [1:0] ROW_Q   = 2'd2;

  // table generation constants, q62 fixed point
  localparam int          Q62_FRAC     = 62;
  localparam int          ROM_SHIFT    = Q62_FRAC - FRAC_BITS;
  localparam int          HORNER_TERMS = 10;
  localparam logic [63:0] Q62_ONE      = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] PI_STEP_Q62  = PI_Q62 / SINE_ROM_ENTRIES;

  // scaled reciprocals of the series divisors, exact floor for 64-bit dividends
  localparam int           RECIP_SHIFT = 74;
  localparam logic [127:0] RECIP_ONE   = 128'd1 << RECIP_SHIFT;
  localparam logic [127:0] SIN_RECIP [HORNER_TERMS] = '{
    RECIP_ONE / 128'd6 + 128'd1,   RECIP_ONE / 128'd20 + 128'd1,
    RECIP_ONE / 128'd42 + 128'd1,  RECIP_ONE / 128'd72 + 128'd1,
    RECIP_ONE / 128'd110 + 128'd1, RECIP_ONE / 128'd156 + 128'd1,
    RECIP_ONE / 128'd210 + 128'd1, RECIP_ONE / 128'd272 + 128'd1,
    RECIP_ONE / 128'd342 + 128'd1, RECIP_ONE / 128'd420 + 128'd1
  };
  localparam logic [127:0] COS_RECIP [HORNER_TERMS] = '{
    RECIP_ONE / 128'd2 + 128'd1,   RECIP_ONE / 128'd12 + 128'd1,
    RECIP_ONE / 128'd30 + 128'd1,  RECIP_ONE / 128'd56 + 128'd1,
    RECIP_ONE / 128'd90 + 128'd1,  RECIP_ONE / 128'd132 + 128'd1,
    RECIP_ONE / 128'd182 + 128'd1, RECIP_ONE / 128'd240 + 128'd1,
    RECIP_ONE / 128'd306 + 128'd1, RECIP_ONE / 128'd380 + 128'd1
  };

  typedef enum logic {
    PLANE_X = 1'b0,
    PLANE_Y = 1'b1
  } erm_plane_t;

  typedef logic signed [TRIG_W-1:0]  erm_trig_t;
  typedef logic signed [ENTRY_W-1:0] erm_entry_t;
  typedef erm_entry_t                erm_mat_t [3][3];
  typedef logic [MAG_W-1:0]          erm_sine_tab_t [SINE_ROM_ENTRIES];

  typedef struct packed {
    erm_plane_t plane;
    erm_trig_t  c;
    erm_trig_t  s;
  } erm_rot_t;

  typedef struct packed {
    erm_trig_t cz;
    erm_trig_t sz;
    erm_rot_t  rot2;
    erm_rot_t  rot3;
  } erm_pkt_t;

  function automatic erm_trig_t erm_trig(input logic [MAG_W-1:0] mag, input logic neg);
    erm_trig_t v;
    v = erm_trig_t'({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic [63:0] erm_mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[Q62_FRAC +: 64];
  endfunction

  // floor(a / d) given the scaled reciprocal of d
  function automatic logic [63:0] erm_div_recip(input logic [63:0] a, input logic [127:0] m);
    logic [191:0] p;
    p = {128'd0, a} * {64'd0, m};
    return p[RECIP_SHIFT +: 64];
  endfunction

  function automatic logic [63:0] erm_sin_q62(input logic [63:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = q * PI_STEP_Q62;
    x2 = erm_mul_q62(x, x);
    t  = Q62_ONE;
    for (int n = HORNER_TERMS; n >= 1; n--) begin
      t = Q62_ONE - erm_div_recip(erm_mul_q62(x2, t), SIN_RECIP[n - 1]);
    end
    return erm_mul_q62(x, t);
  endfunction

  function automatic logic [63:0] erm_cos_q62(input logic [63:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = q * PI_STEP_Q62;
    x2 = erm_mul_q62(x, x);
    t  = Q62_ONE;
    for (int n = HORNER_TERMS; n >= 1; n--) begin
      t = Q62_ONE - erm_div_recip(erm_mul_q62(x2, t), COS_RECIP[n - 1]);
    end
    return t;
  endfunction

  // half-wave magnitude table, floor(|sin| * 4096)
  function automatic erm_sine_tab_t erm_build_sine();
    erm_sine_tab_t tab;
    logic [63:0]   q;
    logic [63:0]   v;
    for (int k = 0; k < SINE_ROM_ENTRIES; k++) begin
      q = (k <= QUARTER_TURN) ? 64'(k) : 64'(SINE_ROM_ENTRIES - k);
      v = (q <= 64'(EIGHTH_TURN)) ? erm_sin_q62(q) : erm_cos_q62(64'(QUARTER_TURN) - q);
      tab[k] = v[ROM_SHIFT +: MAG_W];
    end
    return tab;
  endfunction

endpackage

[rtl/erm_sine_rom.sv]
`timescale 1ns / 1ps
// half-wave sine magnitude rom, two registered read ports
// depends on erm_pkg
module erm_sine_rom (
  input  logic                      clk,
  input  logic [erm_pkg::ROM_AW-1:0] sin_addr,
  input  logic [erm_pkg::ROM_AW-1:0] cos_addr,
  output logic [erm_pkg::MAG_W-1:0]  sin_mag,
  output logic [erm_pkg::MAG_W-1:0]  cos_mag
);
  import erm_pkg::*;

  localparam erm_sine_tab_t SINE_TAB = erm_build_sine();

  logic [MAG_W-1:0] sin_mag_r;
  logic [MAG_W-1:0] cos_mag_r;

  always_ff @(posedge clk) begin
    sin_mag_r <= SINE_TAB[sin_addr];
    cos_mag_r <= SINE_TAB[cos_addr];
  end

  assign sin_mag = sin_mag_r;
  assign cos_mag = cos_mag_r;

endmodule

[rtl/erm_front.sv]
`timescale 1ns / 1ps
// front end: accepts angle transactions, looks up sine and cosine,
// sorts the two late rotations by order. depends on erm_pkg, erm_sine_rom
`include "euler_rotation_matrix_q12_defines.svh"
module erm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_action,
  input  logic [erm_pkg::ANGLE_W-1:0] in_angle_x,
  input  logic [erm_pkg::ANGLE_W-1:0] in_angle_y,
  input  logic [erm_pkg::ANGLE_W-1:0] in_angle_z,
  input  logic                       mid_pop,
  output logic                       mid_push,
  output erm_pkg::erm_pkt_t          mid_pkt
);
  import erm_pkg::*;

  logic                 accept;
  logic [MID_CNT_W-1:0] used_r;
  logic [MID_CNT_W-1:0] used_nxt;
  logic                 valid_r;
  logic                 action_r;
  logic [2:0]           sin_neg_r;
  logic [2:0]           cos_neg_r;

  logic [ANGLE_W-1:0] ang [3];
  logic [ANGLE_W-1:0] cang [3];
  logic [MAG_W-1:0]   sin_mag [3];
  logic [MAG_W-1:0]   cos_mag [3];
  erm_trig_t          sv [3];
  erm_trig_t          cv [3];
  erm_rot_t           rot_x;
  erm_rot_t           rot_y;

  assign in_full = (used_r >= MID_CNT_W'(MID_DEPTH));
  assign accept  = in_push & ~in_full;

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign cang[i] = ang[i] + ANGLE_W'(QUARTER_TURN);

    erm_sine_rom u_rom (
      .clk      (clk),
      .sin_addr (ang[i][ROM_AW-1:0]),
      .cos_addr (cang[i][ROM_AW-1:0]),
      .sin_mag  (sin_mag[i]),
      .cos_mag  (cos_mag[i])
    );

    assign sv[i] = erm_trig(sin_mag[i], sin_neg_r[i]);
    assign cv[i] = erm_trig(cos_mag[i], cos_neg_r[i]);
  end

  always_ff @(posedge clk) begin
    action_r <= in_action;
    for (int i = 0; i < 3; i++) begin
      sin_neg_r[i] <= ang[i][ROM_AW];
      cos_neg_r[i] <= cang[i][ROM_AW];
    end
  end

  always_comb begin
    used_nxt = used_r + MID_CNT_W'(accept) - MID_CNT_W'(mid_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      valid_r <= accept;
    end
  end

  // y rotations carry a negated sine so the back end sees one plane form
  always_comb begin
    rot_x.plane = PLANE_X;
    rot_x.c     = cv[0];
    rot_x.s     = sv[0];
    rot_y.plane = PLANE_Y;
    rot_y.c     = cv[1];
    rot_y.s     = -sv[1];
    mid_pkt.cz  = cv[2];
    mid_pkt.sz  = sv[2];
    case (action_r)
      ORDER_ZYX: begin
        mid_pkt.rot2 = rot_y;
        mid_pkt.rot3 = rot_x;
      end
      ORDER_ZXY: begin
        mid_pkt.rot2 = rot_x;
        mid_pkt.rot3 = rot_y;
      end
      default: begin
        mid_pkt.rot2 = rot_y;
        mid_pkt.rot3 = rot_x;
      end
    endcase
  end

  assign mid_push = valid_r;

  `ERM_CHECK(a_front_credit_bound, 1'b1, used_r <= MID_CNT_W'(MID_DEPTH), "front credits overrun")

endmodule

[rtl/erm_queue.sv]
`timescale 1ns / 1ps
// short queue of decoded transactions between front and back end
// depends on erm_pkg
`include "euler_rotation_matrix_q12_defines.svh"
module erm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  erm_pkg::erm_pkt_t push_pkt,
  input  logic              pop,
  output erm_pkg::erm_pkt_t pop_pkt,
  output logic              empty
);
  import erm_pkg::*;

  erm_pkt_t             mem_r [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_r;
  logic [MID_PTR_W-1:0] rd_ptr_r;
  logic [MID_CNT_W-1:0] cnt_r;
  logic [MID_CNT_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + MID_CNT_W'(push) - MID_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + MID_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + MID_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign pop_pkt = mem_r[rd_ptr_r];
  assign empty   = (cnt_r == '0);

  `ERM_CHECK(a_queue_no_overflow, push && !pop, cnt_r < MID_CNT_W'(MID_DEPTH), "queue overflow")
  `ERM_CHECK(a_queue_no_underflow, pop, !empty, "queue underflow")

endmodule

[rtl/erm_rot_stage.sv]
`timescale 1ns / 1ps
// one plane rotation applied on the left of a q12 matrix, two pipeline steps
// depends on erm_pkg
module erm_rot_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  erm_pkg::erm_mat_t in_m,
  input  erm_pkg::erm_rot_t in_rot,
  output logic              out_valid,
  output erm_pkg::erm_mat_t out_m
);
  import erm_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  logic [1:0] prow;
  logic [1:0] prow_a;
  prod_t      pc_nxt [3];
  prod_t      qs_nxt [3];
  prod_t      ps_nxt [3];
  prod_t      qc_nxt [3];
  prod_t      pc_r [3];
  prod_t      qs_r [3];
  prod_t      ps_r [3];
  prod_t      qc_r [3];
  logic       va_r;
  erm_plane_t pa_r;
  erm_mat_t   ma_r;
  sum_t       sum_p [3];
  sum_t       sum_q [3];
  sum_t       sh_p [3];
  sum_t       sh_q [3];
  erm_mat_t   mb_nxt;
  erm_mat_t   mb_r;
  logic       vb_r;

  // new_p = c*p - s*q, new_q = s*p + c*q
  always_comb begin
    prow = (in_rot.plane == PLANE_X) ? ROW_X_P : ROW_Y_P;
    for (int j = 0; j < 3; j++) begin
      pc_nxt[j] = in_rot.c * in_m[prow][j];
      qs_nxt[j] = in_rot.s * in_m[ROW_Q][j];
      ps_nxt[j] = in_rot.s * in_m[prow][j];
      qc_nxt[j] = in_rot.c * in_m[ROW_Q][j];
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= in_rot.plane;
    ma_r <= in_m;
    for (int j = 0; j < 3; j++) begin
      pc_r[j] <= pc_nxt[j];
      qs_r[j] <= qs_nxt[j];
      ps_r[j] <= ps_nxt[j];
      qc_r[j] <= qc_nxt[j];
    end
  end

  // floor shift then wrap to the entry width
  always_comb begin
    prow_a = (pa_r == PLANE_X) ? ROW_X_P : ROW_Y_P;
    mb_nxt = ma_r;
    for (int j = 0; j < 3; j++) begin
      sum_p[j] = SUM_W'(pc_r[j]) - SUM_W'(qs_r[j]);
      sum_q[j] = SUM_W'(ps_r[j]) + SUM_W'(qc_r[j]);
      sh_p[j]  = sum_p[j] >>> FRAC_BITS;
      sh_q[j]  = sum_q[j] >>> FRAC_BITS;
      mb_nxt[prow_a][j] = sh_p[j][ENTRY_W-1:0];
      mb_nxt[ROW_Q][j]  = sh_q[j][ENTRY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mb_r <= mb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  assign out_valid = vb_r;
  assign out_m     = mb_r;

endmodule

[rtl/erm_back.sv]
`timescale 1ns / 1ps
// back end: builds the z rotation, runs two plane rotation stages
// and holds finished matrices in the result queue. depends on erm_pkg, erm_rot_stage
`include "euler_rotation_matrix_q12_defines.svh"
module erm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  erm_pkg::erm_pkt_t q_pkt,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output erm_pkg::erm_mat_t out_m
);
  import erm_pkg::*;

  logic                 issue;
  logic                 take;
  logic [OUT_CNT_W-1:0] used_r;
  logic [OUT_CNT_W-1:0] used_nxt;
  erm_mat_t             m1;
  erm_rot_t             rot3_d1_r;
  erm_rot_t             rot3_d2_r;
  logic                 s2_valid;
  erm_mat_t             s2_m;
  logic                 s3_valid;
  erm_mat_t             s3_m;

  erm_mat_t             ofifo_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owr_ptr_r;
  logic [OUT_PTR_W-1:0] ord_ptr_r;
  logic [OUT_CNT_W-1:0] ocnt_r;
  logic [OUT_CNT_W-1:0] ocnt_nxt;

  // credits cover both the stages in flight and the result queue
  assign issue = ~q_empty & (used_r < OUT_CNT_W'(OUT_DEPTH));
  assign q_pop = issue;
  assign take  = out_pop & ~out_empty;

  always_comb begin
    used_nxt = used_r + OUT_CNT_W'(issue) - OUT_CNT_W'(take);
    ocnt_nxt = ocnt_r + OUT_CNT_W'(s3_valid) - OUT_CNT_W'(take);
  end

  // z rotation applied to the identity is exact
  always_comb begin
    m1[0][0] = ENTRY_W'(q_pkt.cz);
    m1[0][1] = ENTRY_W'(-q_pkt.sz);
    m1[0][2] = '0;
    m1[1][0] = ENTRY_W'(q_pkt.sz);
    m1[1][1] = ENTRY_W'(q_pkt.cz);
    m1[1][2] = '0;
    m1[2][0] = '0;
    m1[2][1] = '0;
    m1[2][2] = ENTRY_W'(Q12_ONE);
  end

  erm_rot_stage u_stage2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue),
    .in_m      (m1),
    .in_rot    (q_pkt.rot2),
    .out_valid (s2_valid),
    .out_m     (s2_m)
  );

  always_ff @(posedge clk) begin
    rot3_d1_r <= q_pkt.rot3;
    rot3_d2_r <= rot3_d1_r;
  end

  erm_rot_stage u_stage3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_m      (s2_m),
    .in_rot    (rot3_d2_r),
    .out_valid (s3_valid),
    .out_m     (s3_m)
  );

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      ofifo_r[owr_ptr_r] <= s3_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      used_r <= used_nxt;
      ocnt_r <= ocnt_nxt;
      if (s3_valid) begin
        owr_ptr_r <= owr_ptr_r + OUT_PTR_W'(1);
      end
      if (take) begin
        ord_ptr_r <= ord_ptr_r + OUT_PTR_W'(1);
      end
    end
  end

  assign out_empty = (ocnt_r == '0);
  assign out_m     = ofifo_r[ord_ptr_r];

  `ERM_CHECK(a_result_no_overflow, s3_valid && !take, ocnt_r < OUT_CNT_W'(OUT_DEPTH), "result queue overflow")
  `ERM_CHECK_NEXT(a_issue_holds_credit, issue, used_r != '0, "issued transaction lost its credit")

endmodule

[rtl/euler_rotation_matrix_q12.sv]
`timescale 1ns / 1ps
// top level of the euler angle to q12 rotation matrix block
// depends on erm_pkg, erm_front, erm_queue, erm_back
//
// Input channel: drive in_action and the three 12-bit angles with in_push;
// a transaction is taken at a clock edge where in_push is high and in_full
// is low. in_action 0 gives Rx*Ry*Rz, 1 gives Ry*Rx*Rz.
// Result channel: while out_empty is low the oldest matrix sits on
// out_r00..out_r22 (signed q12); it is taken at an edge with out_pop high.
// Throughput: one transaction per cycle while out_pop keeps the result
// queue draining, set by the one-per-cycle sine rom lookup in the front
// end and the two-step multiply/add plane rotation stages in the back
// end; a 4-entry decoded queue sits between them.
// When out_pop stays low the 8-entry result queue fills, the back end stops
// drawing from the decoded queue, and in_full rises once that fills too;
// nothing is dropped. Synchronous reset on rst_n low empties both queues
// and all stages; no transaction is taken while it is held.
module euler_rotation_matrix_q12 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_action,
  input  logic [erm_pkg::ANGLE_W-1:0] in_angle_x,
  input  logic [erm_pkg::ANGLE_W-1:0] in_angle_y,
  input  logic [erm_pkg::ANGLE_W-1:0] in_angle_z,
  output logic                       out_empty,
  input  logic                       out_pop,
  output erm_pkg::erm_entry_t        out_r00,
  output erm_pkg::erm_entry_t        out_r01,
  output erm_pkg::erm_entry_t        out_r02,
  output erm_pkg::erm_entry_t        out_r10,
  output erm_pkg::erm_entry_t        out_r11,
  output erm_pkg::erm_entry_t        out_r12,
  output erm_pkg::erm_entry_t        out_r20,
  output erm_pkg::erm_entry_t        out_r21,
  output erm_pkg::erm_entry_t        out_r22
);
  import erm_pkg::*;

  logic     mid_push;
  logic     mid_pop;
  logic     mid_empty;
  erm_pkt_t mid_in_pkt;
  erm_pkt_t mid_out_pkt;
  erm_mat_t out_m;

  erm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_action  (in_action),
    .in_angle_x (in_angle_x),
    .in_angle_y (in_angle_y),
    .in_angle_z (in_angle_z),
    .mid_pop    (mid_pop),
    .mid_push   (mid_push),
    .mid_pkt    (mid_in_pkt)
  );

  erm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mid_push),
    .push_pkt (mid_in_pkt),
    .pop      (mid_pop),
    .pop_pkt  (mid_out_pkt),
    .empty    (mid_empty)
  );

  erm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mid_empty),
    .q_pkt     (mid_out_pkt),
    .q_pop     (mid_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_m     (out_m)
  );

  assign out_r00 = out_m[0][0];
  assign out_r01 = out_m[0][1];
  assign out_r02 = out_m[0][2];
  assign out_r10 = out_m[1][0];
  assign out_r11 = out_m[1][1];
  assign out_r12 = out_m[1][2];
  assign out_r20 = out_m[2][0];
  assign out_r21 = out_m[2][1];
  assign out_r22 = out_m[2][2];

endmodule
